/* rtl/core/wcm_pkg.sv */
// Package for the window clip and colour math block.
// Holds register indexes, mode codes, the configuration struct and the channel arithmetic.
// Depends on nothing; the top level and wcm_math import it.
package wcm_pkg;

	localparam int PAL_ENTRIES_DEFAULT = 256;
	localparam int COLOR_W = 15;
	localparam int VALUE_W = 16;
	localparam int CH_W = 5;

	typedef enum logic [2:0] {
		REG_WIN_CTRL  = 3'd0,
		REG_MATH_SEL  = 3'd1,
		REG_FIXED     = 3'd2,
		REG_WIN_SEL   = 3'd3,
		REG_W1_LEFT   = 3'd4,
		REG_W1_RIGHT  = 3'd5,
		REG_W2_LEFT   = 3'd6,
		REG_W2_RIGHT  = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_NEVER   = 2'd0,
		MODE_OUTSIDE = 2'd1,
		MODE_INSIDE  = 2'd2,
		MODE_ALWAYS  = 2'd3
	} win_mode_t;

	typedef enum logic [1:0] {
		LOGIC_OR   = 2'd0,
		LOGIC_AND  = 2'd1,
		LOGIC_XOR  = 2'd2,
		LOGIC_XNOR = 2'd3
	} win_logic_t;

	localparam logic [2:0] LAYER_LAST_MATH = 3'd5;

	typedef struct packed {
		win_mode_t          clip_mode;
		win_mode_t          prevent_mode;
		logic               use_sub;
		logic               subtract;
		logic               halve;
		logic [5:0]         layer_en;
		logic [COLOR_W-1:0] fixed_color;
		win_logic_t         win_logic;
		logic               w1_invert;
		logic               w1_enable;
		logic               w2_invert;
		logic               w2_enable;
		logic [7:0]         w1_left;
		logic [7:0]         w1_right;
		logic [7:0]         w2_left;
		logic [7:0]         w2_right;
	} cfg_t;

	// Add or subtract one 5-bit channel, halve if asked, and clamp to 0..31.
	function automatic logic [CH_W-1:0] ch_math(
		input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b,
		input logic            sub,
		input logic            half
	);
		logic [CH_W:0]   sum;
		logic [CH_W:0]   dif;
		logic [CH_W-1:0] res;
		sum = {1'b0, a} + {1'b0, b};
		dif = {1'b0, a} - {1'b0, b};
		if (sub) begin
			if (dif[CH_W]) begin
				res = '0;
			end else if (half) begin
				res = {1'b0, dif[CH_W-1:1]};
			end else begin
				res = dif[CH_W-1:0];
			end
		end else begin
			if (half) begin
				res = sum[CH_W:1];
			end else if (sum[CH_W]) begin
				res = '1;
			end else begin
				res = sum[CH_W-1:0];
			end
		end
		return res;
	endfunction

endpackage

/* rtl/core/window_clip_color_math.sv */
// Top level of the window clip and colour math block: configuration registers,
// palette memories, the two pipeline stages and the handshakes.
// Depends on wcm_pkg, wcm_ram and wcm_math.
//
//   channel  direction  handshake               word
//   in       to block   in_valid / in_stall     operation, x_position, sources, palette write
//   out      from block out_valid / out_stall   pixel_color
//   cfg      to block   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One word is accepted each cycle in_stall is low; a pixel passes stage 1, then pixel_q.
// The palette is held twice so that main and sub indexes are read in the same cycle.
// Reset clears the control state and the configuration registers; the palette is not cleared.
// A stall on the output holds both stages and raises in_stall once the first stage is full.
module window_clip_color_math
	import wcm_pkg::*;
#(
	parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic [7:0]         x_position,
	input  logic               main_direct,
	input  logic [VALUE_W-1:0] main_value,
	input  logic [2:0]         main_layer,
	input  logic               sub_direct,
	input  logic [VALUE_W-1:0] sub_value,
	input  logic [7:0]         palette_address,
	input  logic [COLOR_W-1:0] palette_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [VALUE_W-1:0] pixel_color,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [COLOR_W-1:0] cfg_data
);

	localparam int AW = $clog2(PALETTE_ENTRIES);

	logic [7:0]         color_window_control_q;
	logic [7:0]         color_math_select_q;
	logic [COLOR_W-1:0] fixed_color_q;
	logic [5:0]         color_window_select_q;
	logic [7:0]         window_one_left_q;
	logic [7:0]         window_one_right_q;
	logic [7:0]         window_two_left_q;
	logic [7:0]         window_two_right_q;
	cfg_t               cfg;

	logic               in_accept;
	logic               pal_wr;
	logic               pix_rd;
	logic               s1_adv;
	logic               valid_s1;
	logic [7:0]         x_s1;
	logic               main_direct_s1;
	logic [VALUE_W-1:0] main_value_s1;
	logic [2:0]         main_layer_s1;
	logic               sub_direct_s1;
	logic [VALUE_W-1:0] sub_value_s1;
	logic [COLOR_W-1:0] main_pal_s1;
	logic [COLOR_W-1:0] sub_pal_s1;
	logic [VALUE_W-1:0] pixel_next;
	logic               out_valid_q;
	logic [VALUE_W-1:0] pixel_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_window_control_q <= '0;
			color_math_select_q <= '0;
			fixed_color_q <= '0;
			color_window_select_q <= '0;
			window_one_left_q <= '0;
			window_one_right_q <= '0;
			window_two_left_q <= '0;
			window_two_right_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_WIN_CTRL: color_window_control_q <= cfg_data[7:0];
				REG_MATH_SEL: color_math_select_q <= cfg_data[7:0];
				REG_FIXED:    fixed_color_q <= cfg_data;
				REG_WIN_SEL:  color_window_select_q <= cfg_data[5:0];
				REG_W1_LEFT:  window_one_left_q <= cfg_data[7:0];
				REG_W1_RIGHT: window_one_right_q <= cfg_data[7:0];
				REG_W2_LEFT:  window_two_left_q <= cfg_data[7:0];
				REG_W2_RIGHT: window_two_right_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.clip_mode    = win_mode_t'(color_window_control_q[7:6]);
		cfg.prevent_mode = win_mode_t'(color_window_control_q[5:4]);
		cfg.use_sub      = color_window_control_q[1];
		cfg.subtract     = color_math_select_q[7];
		cfg.halve        = color_math_select_q[6];
		cfg.layer_en     = color_math_select_q[5:0];
		cfg.fixed_color  = fixed_color_q;
		cfg.win_logic    = win_logic_t'(color_window_select_q[5:4]);
		cfg.w1_invert    = color_window_select_q[0];
		cfg.w1_enable    = color_window_select_q[1];
		cfg.w2_invert    = color_window_select_q[2];
		cfg.w2_enable    = color_window_select_q[3];
		cfg.w1_left      = window_one_left_q;
		cfg.w1_right     = window_one_right_q;
		cfg.w2_left      = window_two_left_q;
		cfg.w2_right     = window_two_right_q;
	end

	assign s1_adv    = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !s1_adv;
	assign in_accept = in_valid && !in_stall;
	assign pal_wr    = in_accept && operation;
	assign pix_rd    = in_accept && !operation;

	wcm_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_pal_main (
		.clk     (clk),
		.wr_en   (pal_wr),
		.wr_addr (palette_address[AW-1:0]),
		.wr_data (palette_data),
		.rd_en   (pix_rd),
		.rd_addr (main_value[AW-1:0]),
		.rd_data (main_pal_s1)
	);

	wcm_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_pal_sub (
		.clk     (clk),
		.wr_en   (pal_wr),
		.wr_addr (palette_address[AW-1:0]),
		.wr_data (palette_data),
		.rd_en   (pix_rd),
		.rd_addr (sub_value[AW-1:0]),
		.rd_data (sub_pal_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= pix_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_rd) begin
			x_s1 <= x_position;
			main_direct_s1 <= main_direct;
			main_value_s1 <= main_value;
			main_layer_s1 <= main_layer;
			sub_direct_s1 <= sub_direct;
			sub_value_s1 <= sub_value;
		end
	end

	wcm_math u_math (
		.cfg         (cfg),
		.x_position  (x_s1),
		.main_direct (main_direct_s1),
		.main_value  (main_value_s1),
		.main_layer  (main_layer_s1),
		.sub_direct  (sub_direct_s1),
		.sub_value   (sub_value_s1),
		.main_pal    (main_pal_s1),
		.sub_pal     (sub_pal_s1),
		.pixel_color (pixel_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			pixel_q <= pixel_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_color = pixel_q;

`ifndef NO_ASSERTIONS
	a_stage_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && s1_adv |=> out_valid_q)
		else $error("A pixel leaving the first stage did not reach the output register.");

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("Input stalled without a held pixel in both stages.");

	a_write_no_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		pal_wr |=> !valid_s1)
		else $error("A palette write produced a pixel in the first stage.");

	a_hold_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> $stable(pixel_q) && out_valid_q)
		else $error("The held pixel changed under a stall.");
`endif

endmodule

/* rtl/core/wcm_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Uses no package; width and depth come from parameters.
module wcm_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/core/wcm_math.sv */
// Window test, clip to black and per-channel colour math for one pixel.
// Purely combinational; imports wcm_pkg for the configuration struct and channel function.
module wcm_math
	import wcm_pkg::*;
(
	input  cfg_t               cfg,
	input  logic [7:0]         x_position,
	input  logic               main_direct,
	input  logic [VALUE_W-1:0] main_value,
	input  logic [2:0]         main_layer,
	input  logic               sub_direct,
	input  logic [VALUE_W-1:0] sub_value,
	input  logic [COLOR_W-1:0] main_pal,
	input  logic [COLOR_W-1:0] sub_pal,
	output logic [VALUE_W-1:0] pixel_color
);

	logic               win_a;
	logic               win_b;
	logic               in_win;
	logic               keep;
	logic               no_math;
	logic [VALUE_W-1:0] main_col;
	logic [VALUE_W-1:0] v;
	logic [COLOR_W-1:0] w;
	logic [COLOR_W-1:0] mixed;

	always_comb begin
		win_a = (x_position >= cfg.w1_left) && (x_position <= cfg.w1_right);
		win_b = (x_position >= cfg.w2_left) && (x_position <= cfg.w2_right);
		win_a = win_a ^ cfg.w1_invert;
		win_b = win_b ^ cfg.w2_invert;
		if (cfg.w1_enable && cfg.w2_enable) begin
			case (cfg.win_logic)
				LOGIC_AND:  in_win = win_a & win_b;
				LOGIC_XOR:  in_win = win_a ^ win_b;
				LOGIC_XNOR: in_win = ~(win_a ^ win_b);
				default:    in_win = win_a | win_b;
			endcase
		end else if (cfg.w1_enable) begin
			in_win = win_a;
		end else if (cfg.w2_enable) begin
			in_win = win_b;
		end else begin
			in_win = 1'b0;
		end
	end

	always_comb begin
		case (cfg.clip_mode)
			MODE_NEVER:   keep = 1'b1;
			MODE_OUTSIDE: keep = in_win;
			MODE_INSIDE:  keep = ~in_win;
			default:      keep = 1'b0;
		endcase
		case (cfg.prevent_mode)
			MODE_NEVER:   no_math = 1'b0;
			MODE_OUTSIDE: no_math = ~in_win;
			MODE_INSIDE:  no_math = in_win;
			default:      no_math = 1'b1;
		endcase
		if (main_layer > LAYER_LAST_MATH) begin
			no_math = 1'b1;
		end else if (!cfg.layer_en[main_layer]) begin
			no_math = 1'b1;
		end
	end

	always_comb begin
		main_col = main_direct ? main_value : {1'b0, main_pal};
		v = keep ? main_col : '0;
		if (!cfg.use_sub) begin
			w = cfg.fixed_color;
		end else if (sub_direct) begin
			w = sub_value[COLOR_W-1:0];
		end else begin
			w = sub_pal;
		end
		mixed = {ch_math(v[14:10], w[14:10], cfg.subtract, cfg.halve),
			ch_math(v[9:5], w[9:5], cfg.subtract, cfg.halve),
			ch_math(v[4:0], w[4:0], cfg.subtract, cfg.halve)};
		pixel_color = no_math ? v : {1'b0, mixed};
	end

endmodule
